@@ design/tfo_pkg.sv @@
// Package for the table-free audio oscillator: widths, register indexes,
// mode codes, the configuration struct and the LFSR constants. No dependencies.
`timescale 1ns / 1ps
package tfo_pkg;

	localparam int PHASE_W  = 24;
	localparam int INT_W    = 16;
	localparam int SAMPLE_W = 8;
	localparam int TIMBRE_W = 7;
	localparam int MODE_W   = 2;
	localparam int SEED_W   = 16;
	localparam int IDX_W    = 3;
	localparam int SPREAD_W = 11;
	localparam int SPREAD_SHIFT = 13;
	localparam int SAW_SHIFT    = 10;

	localparam logic [INT_W-1:0]    LFSR_TAPS  = 16'hB400;
	localparam logic [SAMPLE_W-1:0] PWM_BASE   = 8'd127;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MID = 8'd128;
	localparam logic [SAMPLE_W-1:0] K_MIN      = 8'd4;

	localparam logic [MODE_W-1:0] MODE_CRUSH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PWM   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SAW   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOISE = 2'd3;

	localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_TIMBRE = 3'd1;
	localparam logic [IDX_W-1:0] REG_STEP   = 3'd2;
	localparam logic [IDX_W-1:0] REG_SEED   = 3'd3;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [TIMBRE_W-1:0] timbre;
		logic [PHASE_W-1:0]  phase_step;
		logic [SEED_W-1:0]   noise_seed;
		logic [SPREAD_W-1:0] spread;
	} cfg_t;

endpackage

@@ design/tfo_in_if.sv @@
// Input channel: one word per sample tick, carrying the hard-sync bit.
// Depends on nothing.
`timescale 1ns / 1ps
interface tfo_in_if;
	logic valid;
	logic ready;
	logic sync_in;

	modport source (output valid, output sync_in, input ready);
	modport sink (input valid, input sync_in, output ready);
endinterface

@@ design/tfo_out_if.sv @@
// Output channel: one word per sample, sample value and sync carry.
// Depends on nothing.
`timescale 1ns / 1ps
interface tfo_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample;
	logic       sync_out;

	modport source (output valid, output sample, output sync_out, input ready);
	modport sink (input valid, input sample, input sync_out, output ready);
endinterface

@@ design/tfo_cfg.sv @@
// Configuration registers and the precomputed quad saw spread.
// Depends on tfo_pkg.
`timescale 1ns / 1ps
module tfo_cfg
	import tfo_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic [IDX_W-1:0]    idx,
	input  logic [PHASE_W-1:0]  wdata,
	output cfg_t                cfg
);

	logic [MODE_W-1:0]   mode_q;
	logic [TIMBRE_W-1:0] timbre_q;
	logic [PHASE_W-1:0]  step_q;
	logic [SEED_W-1:0]   seed_q;
	logic [SPREAD_W-1:0] spread_q;

	logic [TIMBRE_W-1:0]        nxt_timbre;
	logic [PHASE_W-1:0]         nxt_step;
	logic [INT_W+TIMBRE_W-1:0]  prod;
	logic [SPREAD_W-1:0]        nxt_spread;

	always_comb begin
		nxt_timbre = timbre_q;
		nxt_step   = step_q;
		if (we && idx == REG_TIMBRE) nxt_timbre = wdata[TIMBRE_W-1:0];
		if (we && idx == REG_STEP) nxt_step = wdata;
		prod       = nxt_step[PHASE_W-1 -: INT_W] * nxt_timbre;
		nxt_spread = SPREAD_W'(prod >> SPREAD_SHIFT) + SPREAD_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_CRUSH;
			timbre_q <= '0;
			step_q   <= '0;
			seed_q   <= SEED_W'(1);
			spread_q <= SPREAD_W'(1);
		end else if (we) begin
			case (idx)
				REG_MODE:   mode_q <= wdata[MODE_W-1:0];
				REG_TIMBRE: timbre_q <= nxt_timbre;
				REG_STEP:   step_q <= nxt_step;
				REG_SEED:   seed_q <= wdata[SEED_W-1:0];
				default: ;
			endcase
			spread_q <= nxt_spread;
		end
	end

	assign cfg.mode       = mode_q;
	assign cfg.timbre     = timbre_q;
	assign cfg.phase_step = step_q;
	assign cfg.noise_seed = seed_q;
	assign cfg.spread     = spread_q;

endmodule

@@ design/tfo_voice.sv @@
// Voice state (main phase, detune phases, LFSR, low-pass) and the per-sample
// mode logic. Each accepted word advances the state the current mode uses. Depends on tfo_pkg.
`timescale 1ns / 1ps
module tfo_voice
	import tfo_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                sync,
	input  cfg_t                cfg,
	output logic [SAMPLE_W-1:0] sample,
	output logic                carry
);

	logic [PHASE_W-1:0]  phase_q;
	logic [INT_W-1:0]    det_q [3];
	logic [INT_W-1:0]    lfsr_q;
	logic [SAMPLE_W-1:0] lp_q;

	logic [PHASE_W:0]    sum;
	logic [PHASE_W-1:0]  nxt_phase;
	logic [SAMPLE_W-1:0] top;
	logic [SAMPLE_W-1:0] x2, xmask, crush, pwm_thr, saw;
	logic [INT_W-1:0]    inc0, spr;
	logic [INT_W-1:0]    inc [3];
	logic [INT_W-1:0]    nxt_det [3];
	logic [SAMPLE_W-1:0] k, kraw, n, nxt_lp, hp;
	logic [INT_W-1:0]    r0, r1;
	logic [INT_W-1:0]    mix;

	always_comb begin
		sum       = {1'b0, (sync ? PHASE_W'(0) : phase_q)} + {1'b0, cfg.phase_step};
		nxt_phase = sum[PHASE_W-1:0];
		top       = sum[PHASE_W-1 -: SAMPLE_W];

		x2    = {cfg.timbre, 1'b0};
		xmask = ~{1'b0, cfg.timbre};
		crush = ((top ^ x2) & xmask) + SAMPLE_W'(cfg.timbre >> 1);

		pwm_thr = PWM_BASE + SAMPLE_W'(cfg.timbre);

		inc0 = cfg.phase_step[PHASE_W-1 -: INT_W];
		spr  = INT_W'(cfg.spread);
		inc[0] = inc0 + spr;
		inc[1] = inc[0] + spr;
		inc[2] = inc[1] + spr;
		for (int i = 0; i < 3; i++) nxt_det[i] = det_q[i] + inc[i];
		saw = SAMPLE_W'(sum[PHASE_W-1 -: (INT_W-SAW_SHIFT)])
			+ SAMPLE_W'(nxt_det[0] >> SAW_SHIFT)
			+ SAMPLE_W'(nxt_det[1] >> SAW_SHIFT)
			+ SAMPLE_W'(nxt_det[2] >> SAW_SHIFT);

		kraw = {cfg.timbre[TIMBRE_W-2:0], 2'b00};
		k    = (kraw <= K_MIN) ? K_MIN : kraw;
		r0   = sync ? cfg.noise_seed : ((lfsr_q == '0) ? INT_W'(1) : lfsr_q);
		r1   = {1'b0, r0[INT_W-1:1]} ^ (r0[0] ? LFSR_TAPS : '0);
		n    = r1[INT_W-1 -: SAMPLE_W];
		mix  = (INT_W'(lp_q) * INT_W'(8'd255 - k)) + (INT_W'(n) * INT_W'(k));
		nxt_lp = mix[INT_W-1 -: SAMPLE_W];
		hp     = n - nxt_lp - SAMPLE_MID;

		carry = sum[PHASE_W];
		case (cfg.mode)
			MODE_CRUSH: sample = crush;
			MODE_PWM:   sample = (top < pwm_thr) ? '0 : '1;
			MODE_SAW:   sample = saw;
			MODE_NOISE: begin
				sample = cfg.timbre[TIMBRE_W-1] ? hp : nxt_lp;
				carry  = 1'b0;
			end
			default:    sample = crush;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			for (int i = 0; i < 3; i++) det_q[i] <= '0;
			lfsr_q  <= INT_W'(1);
			lp_q    <= '0;
		end else if (step) begin
			if (cfg.mode == MODE_NOISE) begin
				lfsr_q <= r1;
				lp_q   <= nxt_lp;
			end else begin
				phase_q <= nxt_phase;
				if (cfg.mode == MODE_SAW) begin
					for (int i = 0; i < 3; i++) det_q[i] <= nxt_det[i];
				end
			end
		end
	end

endmodule

@@ design/table_free_audio_oscillator_top.sv @@
// Top level of the table-free audio oscillator: config port, voice and output
// register. Depends on tfo_pkg, tfo_in_if, tfo_out_if, tfo_cfg, tfo_voice.
//
// Usage:
//   din carries one word per sample tick (sync_in). dout returns one word per
//   input word: an 8-bit unsigned sample and the phase carry (sync_out).
//   Config registers are written through cfg_we / cfg_idx / cfg_wdata:
//   0 mode, 1 timbre, 2 phase_step, 3 noise_seed; other indexes are ignored.
//   Write config only while no sample is in flight.
//   Timing: the sample for an accepted word is registered and valid in the
//   cycle after acceptance. Throughput: one word per cycle while dout is not
//   stalled; the voice state and the mode logic advance in the accept cycle and
//   the result lands in a single output register.
//   Stall: while dout is stalled the output register holds its word and
//   din.ready drops; a new word is taken in the same cycle the held one leaves.
//   Reset: phases, low-pass, timbre, step cleared; LFSR, noise_seed and spread
//   set to 1, mode bit-crush, output register empty. No clearing pass is needed.
`timescale 1ns / 1ps
module table_free_audio_oscillator_top
	import tfo_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	tfo_in_if.sink             din,
	tfo_out_if.source          dout,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_idx,
	input  logic [PHASE_W-1:0] cfg_wdata
);

	cfg_t                cfg;
	logic                in_fire;
	logic [SAMPLE_W-1:0] v_sample;
	logic                v_carry;
	logic                valid_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                carry_q;

	tfo_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.idx   (cfg_idx),
		.wdata (cfg_wdata),
		.cfg   (cfg)
	);

	assign din.ready = !valid_q || dout.ready;
	assign in_fire   = din.valid && din.ready;

	tfo_voice u_voice (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (in_fire),
		.sync  (din.sync_in),
		.cfg   (cfg),
		.sample(v_sample),
		.carry (v_carry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (din.ready) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= v_sample;
			carry_q  <= v_carry;
		end
	end

	assign dout.valid    = valid_q;
	assign dout.sample   = sample_q;
	assign dout.sync_out = carry_q;

	a_fire_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> dout.valid)
		else $error("accepted word produced no output");

	a_noise_no_carry: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cfg.mode == MODE_NOISE |=> !dout.sync_out)
		else $error("sync carry set in noise mode");

	a_pwm_levels: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cfg.mode == MODE_PWM |=> dout.sample == '0 || dout.sample == '1)
		else $error("pwm sample not at a rail");

endmodule
